// ===== design/rau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, codes and the cross-product sequence table of the rational
// arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [2:0] {
    K_ADD    = 3'd0,
    K_SUB    = 3'd1,
    K_MUL    = 3'd2,
    K_DIV    = 3'd3,
    K_REDUCE = 3'd4,
    K_CMP    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } order_e;

  typedef enum logic [2:0] {
    MS_LN_RD,
    MS_RN_LD,
    MS_LD_RD,
    MS_LN_RN,
    MS_LD_RN
  } mul_sel_e;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_NUM_SET,
    WB_NUM_ADD,
    WB_NUM_SUB,
    WB_DEN_SET,
    WB_X_SET
  } wb_dst_e;

  typedef enum logic [1:0] {
    DS_GCD,
    DS_NUM,
    DS_DEN
  } div_src_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_WB,
    S_GCD_CHK,
    S_GCD_WAIT,
    S_NUM_WAIT,
    S_DEN_WAIT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] left_num;
    logic signed [31:0] left_den;
    logic signed [31:0] right_num;
    logic signed [31:0] right_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic signed [31:0] result_den;
    logic [1:0]         order;
    logic               error;
  } rau_out_t;

  typedef struct packed {
    logic     last;
    mul_sel_e sel;
    wb_dst_e  dst;
  } mul_step_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     wb_en;
    wb_dst_e  wb_dst;
    logic     div_start;
    div_src_e div_src;
    logic     gcd_upd;
    logic     num_upd;
    logic     den_upd;
    logic     out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       a_zero;
    logic       b_zero;
    logic       div_done;
  } rau_status_t;

  // Multiply schedule per kind: one product per step, written back to dst.
  function automatic mul_step_t mul_prog(logic [2:0] kind, logic [1:0] step);
    mul_step_t s;
    s = '{last: 1'b1, sel: MS_LN_RD, dst: WB_NONE};
    unique case (kind)
      K_ADD, K_SUB: begin
        unique case (step)
          2'd0:    s = '{last: 1'b0, sel: MS_LN_RD, dst: WB_NUM_SET};
          2'd1:    s = '{last: 1'b0, sel: MS_RN_LD,
                         dst: (kind == K_ADD) ? WB_NUM_ADD : WB_NUM_SUB};
          default: s = '{last: 1'b1, sel: MS_LD_RD, dst: WB_DEN_SET};
        endcase
      end
      K_MUL: begin
        if (step == 2'd0) s = '{last: 1'b0, sel: MS_LN_RN, dst: WB_NUM_SET};
        else              s = '{last: 1'b1, sel: MS_LD_RD, dst: WB_DEN_SET};
      end
      K_DIV: begin
        if (step == 2'd0) s = '{last: 1'b0, sel: MS_LN_RD, dst: WB_NUM_SET};
        else              s = '{last: 1'b1, sel: MS_LD_RN, dst: WB_DEN_SET};
      end
      K_CMP: begin
        if (step == 2'd0) s = '{last: 1'b0, sel: MS_LN_RD, dst: WB_X_SET};
        else              s = '{last: 1'b1, sel: MS_RN_LD, dst: WB_NONE};
      end
      default: s = '{last: 1'b1, sel: MS_LN_RD, dst: WB_NONE};
    endcase
    return s;
  endfunction

endpackage

// ===== design/rau_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  q_r, q_nxt;
  logic [W-1:0]  r_r, r_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {r_r, q_r[W-1]};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (!diff[W]) begin
        r_nxt = diff[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        r_nxt = trial[W-1:0];
        q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

// ===== design/rau_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: steps the multiply schedule, the gcd loop and the result handoff.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [2:0]           in_kind,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rau_pkg::rau_cmd_t    cmd,
  input  rau_pkg::rau_status_t sts
);
  import rau_pkg::*;

  state_e    state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic      ovld_r, ovld_nxt;
  mul_step_t prog;
  logic      out_free;

  assign prog     = mul_prog(sts.kind, step_r);
  assign out_free = !ovld_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          step_nxt = 2'd0;
          priority if (in_kind == K_REDUCE) state_nxt = S_GCD_CHK;
          else if (in_kind == K_ADD || in_kind == K_SUB || in_kind == K_MUL ||
                   in_kind == K_DIV || in_kind == K_CMP) state_nxt = S_MUL;
          else state_nxt = S_FINISH;
        end
      end
      S_MUL: state_nxt = S_WB;
      S_WB: begin
        if (prog.last) state_nxt = S_FINISH;
        else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_GCD_CHK: begin
        priority if (!sts.b_zero) state_nxt = S_GCD_WAIT;
        else if (sts.a_zero)      state_nxt = S_FINISH;
        else                      state_nxt = S_NUM_WAIT;
      end
      S_GCD_WAIT: if (sts.div_done) state_nxt = S_GCD_CHK;
      S_NUM_WAIT: if (sts.div_done) state_nxt = S_DEN_WAIT;
      S_DEN_WAIT: if (sts.div_done) state_nxt = S_FINISH;
      S_FINISH:   if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = prog.sel;
    cmd.wb_dst  = prog.dst;
    cmd.div_src = DS_GCD;
    in_stall    = 1'b1;
    ovld_nxt    = ovld_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_MUL: cmd.mul_en = 1'b1;
      S_WB:  cmd.wb_en  = 1'b1;
      S_GCD_CHK: begin
        priority if (!sts.b_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DS_GCD;
        end else if (!sts.a_zero) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = DS_NUM;
        end
      end
      S_GCD_WAIT: cmd.gcd_upd = sts.div_done;
      S_NUM_WAIT: begin
        cmd.num_upd   = sts.div_done;
        cmd.div_start = sts.div_done;
        cmd.div_src   = DS_DEN;
      end
      S_DEN_WAIT: cmd.den_upd = sts.div_done;
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          ovld_nxt     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= 2'd0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_valid = ovld_r;

endmodule

// ===== design/rau_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, shared multiplier, gcd registers with the
// divider, and the result register.
// ----------------------------------------------------------------------------
module rau_dp #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rau_pkg::rau_in_t     in_data,
  input  rau_pkg::rau_cmd_t    cmd,
  output rau_pkg::rau_status_t sts,
  output rau_pkg::rau_out_t    out_data
);
  import rau_pkg::*;

  localparam int PW = 2 * W + 2;

  logic [2:0]         kind_r;
  logic signed [W:0]  ln_r, ld_r, rn_r, rd_r;
  logic               dzero_r, neg_r;
  logic [W-1:0]       mn_r, md_r, a_r, b_r;
  logic signed [PW-1:0] prod_r, x_r;
  logic [W-1:0]       num_r, num_nxt, den_r, den_nxt;
  rau_out_t           out_r, res;

  logic signed [W:0]  s_ln, s_ld, s_rn, s_rd, c_ln, c_ld, c_rn, c_rd;
  logic signed [W:0]  op_a, op_b;
  logic signed [PW-1:0] prod_nxt;
  logic [W-1:0]       div_a, div_b, quot, rem, qneg;
  logic               div_done;

  assign s_ln = {in_data.left_num[W-1], in_data.left_num[W-1:0]};
  assign s_ld = {in_data.left_den[W-1], in_data.left_den[W-1:0]};
  assign s_rn = {in_data.right_num[W-1], in_data.right_num[W-1:0]};
  assign s_rd = {in_data.right_den[W-1], in_data.right_den[W-1:0]};

  // compare works on fractions with nonnegative denominators
  always_comb begin
    c_ln = s_ln;
    c_ld = s_ld;
    c_rn = s_rn;
    c_rd = s_rd;
    if (in_data.kind == K_CMP) begin
      if (s_ld < 0) begin
        c_ln = -s_ln;
        c_ld = -s_ld;
      end
      if (s_rd < 0) begin
        c_rn = -s_rn;
        c_rd = -s_rd;
      end
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MS_LN_RD: begin op_a = ln_r; op_b = rd_r; end
      MS_RN_LD: begin op_a = rn_r; op_b = ld_r; end
      MS_LD_RD: begin op_a = ld_r; op_b = rd_r; end
      MS_LN_RN: begin op_a = ln_r; op_b = rn_r; end
      MS_LD_RN: begin op_a = ld_r; op_b = rn_r; end
      default:  begin op_a = ln_r; op_b = rd_r; end
    endcase
  end

  assign prod_nxt = op_a * op_b;

  always_comb begin
    unique case (cmd.div_src)
      DS_GCD:  begin div_a = a_r;  div_b = b_r; end
      DS_NUM:  begin div_a = mn_r; div_b = a_r; end
      DS_DEN:  begin div_a = md_r; div_b = a_r; end
      default: begin div_a = a_r;  div_b = b_r; end
    endcase
  end

  rau_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  assign qneg = neg_r ? (W'(0) - quot) : quot;

  always_comb begin
    num_nxt = num_r;
    den_nxt = den_r;
    if (cmd.wb_en) begin
      unique case (cmd.wb_dst)
        WB_NUM_SET: num_nxt = prod_r[W-1:0];
        WB_NUM_ADD: num_nxt = num_r + prod_r[W-1:0];
        WB_NUM_SUB: num_nxt = num_r - prod_r[W-1:0];
        WB_DEN_SET: den_nxt = prod_r[W-1:0];
        default: ;
      endcase
    end
    if (cmd.num_upd) num_nxt = qneg;
    if (cmd.den_upd) den_nxt = quot;
  end

  // result formation
  always_comb begin
    res = '0;
    unique case (kind_r)
      K_ADD, K_SUB, K_MUL, K_DIV: begin
        res.result_num = 32'(signed'(num_r));
        res.result_den = 32'(signed'(den_r));
        res.error      = (den_r == '0);
      end
      K_REDUCE: begin
        if (a_r == '0) res.error = 1'b1;
        else begin
          res.result_num = 32'(signed'(num_r));
          res.result_den = 32'(signed'(den_r));
          res.error      = (den_r == '0);
        end
      end
      K_CMP: begin
        priority if (x_r < prod_r) res.order = ORD_LESS;
        else if (x_r == prod_r)    res.order = ORD_EQUAL;
        else                       res.order = ORD_GREATER;
        res.error = dzero_r;
      end
      default: res.error = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_data.kind;
      ln_r    <= c_ln;
      ld_r    <= c_ld;
      rn_r    <= c_rn;
      rd_r    <= c_rd;
      dzero_r <= (s_ld == 0) || (s_rd == 0);
      neg_r   <= s_ln[W] ^ s_ld[W];
      mn_r    <= s_ln[W] ? (W'(0) - s_ln[W-1:0]) : s_ln[W-1:0];
      md_r    <= s_ld[W] ? (W'(0) - s_ld[W-1:0]) : s_ld[W-1:0];
      a_r     <= s_ln[W] ? (W'(0) - s_ln[W-1:0]) : s_ln[W-1:0];
      b_r     <= s_ld[W] ? (W'(0) - s_ld[W-1:0]) : s_ld[W-1:0];
    end else if (cmd.gcd_upd) begin
      a_r <= b_r;
      b_r <= rem;
    end
    if (cmd.mul_en) prod_r <= prod_nxt;
    if (cmd.wb_en && cmd.wb_dst == WB_X_SET) x_r <= prod_r;
    num_r <= num_nxt;
    den_r <= den_nxt;
    if (cmd.out_load) out_r <= res;
  end

  assign sts.kind     = kind_r;
  assign sts.a_zero   = (a_r == '0);
  assign sts.b_zero   = (b_r == '0);
  assign sts.div_done = div_done;
  assign out_data     = out_r;

endmodule

// ===== design/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide, reduce and compare on signed fractions.
// ----------------------------------------------------------------------------
// One item is in flight at a time. Add, subtract, multiply, divide and compare
// run through one shared (WORD_BITS+1)-bit signed multiplier, each product
// taking an S_MUL and an S_WB state: add and subtract use three products,
// multiply, divide and compare two. Reduce runs the Euclidean gcd on a
// restoring divider that yields one quotient bit per cycle while busy. A
// finished beat waits in the output register while the next item is taken.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rau_pkg::rau_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  rau_cmd_t    cmd;
  rau_status_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rau_dp #(.W(WORD_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== tb/sv/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Drives directed and random fraction operations through the unit under
// random valid gaps and result stalls, and checks every result beat in order
// against a predictor of the fraction arithmetic or a directed row's value.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam logic [31:0] W_MAX = 32'h7fff_ffff;
  localparam logic [31:0] W_ONES = 32'hffff_ffff;
  localparam int RANDOM_ITEMS = 1330;
  localparam int DRAIN_CYCLES = 2000;

  typedef struct {
    rau_in_t  stim;
    bit       typed;
    rau_out_t want;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  rau_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  rau_out_t out_data;

  rau_out_t pending_results[$];
  dir_row_t dir_rows[$];
  int       send_idle_pct = 30;
  int       recv_idle_pct = 62;
  int       error_count = 0;
  int       beats_checked = 0;
  int       reduce_count = 0;
  int       compare_count = 0;

  rational_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic rau_in_t op(logic [2:0] k, logic [31:0] ln, logic [31:0] ld,
                                 logic [31:0] rn, logic [31:0] rd);
    rau_in_t it;
    it.kind = k;
    it.left_num = ln;
    it.left_den = ld;
    it.right_num = rn;
    it.right_den = rd;
    return it;
  endfunction

  function automatic rau_out_t res(logic [31:0] n, logic [31:0] d, logic [1:0] o,
                                   logic e);
    rau_out_t r;
    r.result_num = n;
    r.result_den = d;
    r.order = o;
    r.error = e;
    return r;
  endfunction

  // Fraction arithmetic at 32 bits; compare is exact in 64 bits.
  function automatic rau_out_t fraction_result(rau_in_t it);
    rau_out_t    r;
    logic [31:0] ln, ld, rn, rd;
    longint      sn, sd, bn, bd, x, y;
    logic [63:0] mn, md, a, b, t, qn, qd, sq;
    logic        neg;
    r = '0;
    ln = it.left_num;
    ld = it.left_den;
    rn = it.right_num;
    rd = it.right_den;
    case (it.kind)
      K_ADD, K_SUB, K_MUL, K_DIV: begin
        case (it.kind)
          K_ADD: r.result_num = ln * rd + rn * ld;
          K_SUB: r.result_num = ln * rd - rn * ld;
          K_MUL: r.result_num = ln * rn;
          default: r.result_num = ln * rd;
        endcase
        r.result_den = (it.kind == K_DIV) ? ld * rn : ld * rd;
        r.error = (r.result_den == 0);
      end
      K_REDUCE: begin
        sn = longint'($signed(ln));
        sd = longint'($signed(ld));
        mn = (sn < 0) ? -sn : sn;
        md = (sd < 0) ? -sd : sd;
        a = mn;
        b = md;
        while (b != 0) begin
          t = a % b;
          a = b;
          b = t;
        end
        if (a == 0) begin
          r.error = 1'b1;
        end else begin
          neg = (sn < 0) != (sd < 0);
          qn = mn / a;
          qd = md / a;
          sq = neg ? -qn : qn;
          r.result_num = sq[31:0];
          r.result_den = qd[31:0];
          r.error = (qd[31:0] == 0);
        end
      end
      K_CMP: begin
        sn = longint'($signed(ln));
        sd = longint'($signed(ld));
        bn = longint'($signed(rn));
        bd = longint'($signed(rd));
        if (sd < 0) begin
          sn = -sn;
          sd = -sd;
        end
        if (bd < 0) begin
          bn = -bn;
          bd = -bd;
        end
        x = sn * bd;
        y = bn * sd;
        r.order = (x < y) ? ORD_LESS : ((x == y) ? ORD_EQUAL : ORD_GREATER);
        r.error = (ld == 0) || (rd == 0);
      end
      default: r.error = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0, 1: w = $urandom;
      2: w = $urandom_range(0, 40) - 20;
      3: begin
        case ($urandom_range(0, 4))
          0: w = W_MIN;
          1: w = W_MAX;
          2: w = '0;
          3: w = 32'd1;
          default: w = W_ONES;
        endcase
      end
      default: w = $urandom_range(0, 2000) - 1000;
    endcase
    return w;
  endfunction

  function automatic rau_in_t rand_item();
    rau_in_t     it;
    logic [31:0] common;
    int          pick;
    it = op(K_ADD, rand_word(), rand_word(), rand_word(), rand_word());
    pick = $urandom_range(0, 99);
    if (pick < 16) it.kind = K_ADD;
    else if (pick < 32) it.kind = K_SUB;
    else if (pick < 48) it.kind = K_MUL;
    else if (pick < 64) it.kind = K_DIV;
    else if (pick < 80) it.kind = K_CMP;
    else if (pick < 96) it.kind = K_REDUCE;
    else it.kind = $urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI;
    // Share a factor so reduce has real work to do.
    if (it.kind == K_REDUCE && $urandom_range(0, 1)) begin
      common = $urandom_range(1, 5000);
      it.left_num = common * ($urandom_range(0, 20000) - 10000);
      it.left_den = common * ($urandom_range(0, 20000) - 10000);
    end
    return it;
  endfunction

  task automatic send_beat(rau_in_t it, rau_out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(want);
    if (it.kind == K_REDUCE) reduce_count++;
    if (it.kind == K_CMP) compare_count++;
  endtask

  // Receiver: randomize stall and check accepted result beats.
  always @(posedge clk) begin
    rau_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, out_data);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (out_data.result_num !== want.result_num)
          $display("%0t: result_num expected %h got %h", $time, want.result_num,
                   out_data.result_num);
        if (out_data.result_den !== want.result_den)
          $display("%0t: result_den expected %h got %h", $time, want.result_den,
                   out_data.result_den);
        if (out_data.order !== want.order)
          $display("%0t: order expected %0d got %0d", $time, want.order,
                   out_data.order);
        if (out_data.error !== want.error)
          $display("%0t: error expected %0d got %0d", $time, want.error,
                   out_data.error);
        if (out_data !== want) error_count++;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  initial begin
    dir_row_t row;
    rau_in_t  it;
    dir_rows.push_back('{op(K_ADD, 1, 2, 1, 3), 1, res(5, 6, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_SUB, 1, 2, 1, 3), 1, res(1, 6, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_MUL, 2, 3, 4, 5), 1, res(8, 15, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_DIV, 2, 3, 4, 5), 1, res(10, 12, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_DIV, 1, 2, 0, 5), 1, res(5, 0, ORD_LESS, 1)});
    dir_rows.push_back('{op(K_ADD, W_MAX, W_MAX, W_MAX, W_MIN), 0, '0});
    dir_rows.push_back('{op(K_SUB, W_MIN, W_ONES, W_MAX, W_MIN), 0, '0});
    dir_rows.push_back('{op(K_MUL, W_MIN, W_MIN, W_ONES, W_MAX), 0, '0});
    dir_rows.push_back('{op(K_REDUCE, 0, 0, 0, 0), 1, res(0, 0, ORD_LESS, 1)});
    dir_rows.push_back('{op(K_REDUCE, 5, 0, 0, 0), 1, res(1, 0, ORD_LESS, 1)});
    dir_rows.push_back('{op(K_REDUCE, -5, 0, 0, 0), 1, res(W_ONES, 0, ORD_LESS, 1)});
    dir_rows.push_back('{op(K_REDUCE, 6, -4, 0, 0), 1, res(-3, 2, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_REDUCE, W_MIN, W_ONES, 0, 0), 1, res(W_MIN, 1, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_REDUCE, W_MIN, W_MIN, 0, 0), 1, res(1, 1, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_REDUCE, 0, -7, 0, 0), 1, res(0, 1, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_REDUCE, 10, 4, 99, 0), 1, res(5, 2, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_REDUCE, W_MAX, W_MIN, W_ONES, W_ONES), 0, '0});
    dir_rows.push_back('{op(K_CMP, 1, 2, 1, 3), 1, res(0, 0, ORD_GREATER, 0)});
    dir_rows.push_back('{op(K_CMP, 1, -2, -1, 2), 1, res(0, 0, ORD_EQUAL, 0)});
    dir_rows.push_back('{op(K_CMP, W_MIN, 1, W_MAX, 1), 1, res(0, 0, ORD_LESS, 0)});
    dir_rows.push_back('{op(K_CMP, 1, 0, 1, 1), 1, res(0, 0, ORD_GREATER, 1)});
    dir_rows.push_back('{op(K_CMP, W_MIN, W_MIN, W_MAX, W_MIN), 0, '0});
    dir_rows.push_back('{op(KIND_SPARE_LO, 3, 4, 5, 6), 1, res(0, 0, ORD_LESS, 1)});
    dir_rows.push_back('{op(KIND_SPARE_HI, W_ONES, W_ONES, W_ONES, W_ONES), 1,
                        res(0, 0, ORD_LESS, 1)});

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_beat(row.stim, row.typed ? row.want : fraction_result(row.stim));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        // Hold off until the unit has drained, then swap the idle ratios.
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        send_idle_pct = 62;
        recv_idle_pct = 30;
      end
      if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      it = rand_item();
      send_beat(it, fraction_result(it));
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d result beats, %0d reduce and %0d compare among them,",
             beats_checked, reduce_count, compare_count);
    $display("under three idle mixes on sender and receiver.");
    if (error_count == 0) begin
      $display("tb_rational_arithmetic_unit: clean");
    end else begin
      $display("tb_rational_arithmetic_unit: errors");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("tb_rational_arithmetic_unit: errors");
    $finish;
  end

endmodule
